// ===== rtl/fdbb_pkg.sv =====
`default_nettype none

package fdbb_pkg;

    localparam int SAMPLE_STEP  = 4;
    localparam int MAX_DIM      = 4096;
    localparam int COORD_W      = $clog2(MAX_DIM);
    localparam int PHASE_W      = (SAMPLE_STEP > 1) ? $clog2(SAMPLE_STEP) : 1;
    localparam int WIDTH_W      = 13;
    localparam int THRESH_W     = 11;
    localparam int CFG_INDEX_W  = 1;
    localparam int CFG_DATA_W   = 13;
    localparam int CHAN_W       = 8;
    localparam int SUM_W        = CHAN_W + 2;

    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_WIDTH    = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_DIFF_THRESHOLD = 1'b1;

    localparam logic [WIDTH_W-1:0]  FRAME_WIDTH_RESET = 13'd1920;
    localparam logic [THRESH_W-1:0] THRESHOLD_RESET   = 11'd30;

    typedef struct packed {
        logic [CHAN_W-1:0] b_red;
        logic [CHAN_W-1:0] b_green;
        logic [CHAN_W-1:0] b_blue;
        logic [CHAN_W-1:0] a_red;
        logic [CHAN_W-1:0] a_green;
        logic [CHAN_W-1:0] a_blue;
    } pixel_pair_t;

    typedef struct packed {
        logic               found;
        logic [COORD_W-1:0] box_left;
        logic [COORD_W-1:0] box_top;
        logic [COORD_W-1:0] box_right;
        logic [COORD_W-1:0] box_bottom;
    } box_t;

endpackage

`default_nettype wire

// ===== rtl/fdbb_pixel_diff.sv =====
`default_nettype none

module fdbb_pixel_diff (
    input  wire fdbb_pkg::pixel_pair_t              pixel,
    input  wire logic signed [fdbb_pkg::THRESH_W-1:0] threshold,
    output logic                                    changed
);
    import fdbb_pkg::*;

    logic [CHAN_W-1:0]   diff_blue;
    logic [CHAN_W-1:0]   diff_green;
    logic [CHAN_W-1:0]   diff_red;
    logic [SUM_W-1:0]    sum;
    logic signed [THRESH_W-1:0] sum_signed;

    always_comb
    begin
        diff_blue  = (pixel.a_blue > pixel.b_blue) ? pixel.a_blue - pixel.b_blue
                                                   : pixel.b_blue - pixel.a_blue;
        diff_green = (pixel.a_green > pixel.b_green) ? pixel.a_green - pixel.b_green
                                                     : pixel.b_green - pixel.a_green;
        diff_red   = (pixel.a_red > pixel.b_red) ? pixel.a_red - pixel.b_red
                                                 : pixel.b_red - pixel.a_red;
        sum = {2'b00, diff_blue} + {2'b00, diff_green} + {2'b00, diff_red};
        // The sum is at most 765, so one leading zero makes it a positive signed value.
        sum_signed = $signed({{(THRESH_W-SUM_W){1'b0}}, sum});
        changed = sum_signed > threshold;
    end

endmodule

`default_nettype wire

// ===== rtl/fdbb_box_tracker.sv =====
`default_nettype none

module fdbb_box_tracker (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            step,
    input  wire logic                            changed,
    input  wire logic                            last,
    input  wire logic [fdbb_pkg::WIDTH_W-1:0]    frame_width,
    output fdbb_pkg::box_t                       result
);
    import fdbb_pkg::*;

    localparam logic [COORD_W-1:0] COORD_ONES = {COORD_W{1'b1}};
    localparam logic [WIDTH_W-1:0] MAX_WIDTH  = WIDTH_W'(MAX_DIM);
    localparam logic [PHASE_W-1:0] PHASE_LAST = PHASE_W'(SAMPLE_STEP - 1);

    logic [COORD_W-1:0] column_reg, column_next;
    logic [COORD_W-1:0] row_reg, row_next;
    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic [COORD_W-1:0] min_col_reg, min_col_next;
    logic [COORD_W-1:0] max_col_reg, max_col_next;
    logic [COORD_W-1:0] min_row_reg, min_row_next;
    logic [COORD_W-1:0] max_row_reg, max_row_next;
    logic               any_reg, any_next;

    logic [COORD_W-1:0] upd_min_col, upd_max_col, upd_min_row, upd_max_row;
    logic               upd_any;
    logic               hit;
    logic [WIDTH_W-1:0] width_eff;
    logic [WIDTH_W-1:0] column_plus;

    always_comb
    begin
        if (frame_width == '0)
            width_eff = WIDTH_W'(1);
        else if (frame_width > MAX_WIDTH)
            width_eff = MAX_WIDTH;
        else
            width_eff = frame_width;

        hit = (phase_reg == '0) && changed;

        upd_min_col = (hit && column_reg < min_col_reg) ? column_reg : min_col_reg;
        upd_max_col = (hit && column_reg > max_col_reg) ? column_reg : max_col_reg;
        upd_min_row = (hit && row_reg < min_row_reg) ? row_reg : min_row_reg;
        upd_max_row = (hit && row_reg > max_row_reg) ? row_reg : max_row_reg;
        upd_any     = any_reg | hit;

        result.found      = upd_any;
        result.box_left   = upd_any ? upd_min_col : '0;
        result.box_top    = upd_any ? upd_min_row : '0;
        result.box_right  = upd_any ? upd_max_col : '0;
        result.box_bottom = upd_any ? upd_max_row : '0;

        column_plus = {1'b0, column_reg} + WIDTH_W'(1);

        column_next  = column_reg;
        row_next     = row_reg;
        phase_next   = phase_reg;
        min_col_next = min_col_reg;
        max_col_next = max_col_reg;
        min_row_next = min_row_reg;
        max_row_next = max_row_reg;
        any_next     = any_reg;

        if (step)
        begin
            if (last)
            begin
                // The frame ends here: start the next one from a clean box.
                column_next  = '0;
                row_next     = '0;
                phase_next   = '0;
                min_col_next = COORD_ONES;
                max_col_next = '0;
                min_row_next = COORD_ONES;
                max_row_next = '0;
                any_next     = 1'b0;
            end
            else
            begin
                min_col_next = upd_min_col;
                max_col_next = upd_max_col;
                min_row_next = upd_min_row;
                max_row_next = upd_max_row;
                any_next     = upd_any;
                phase_next   = (phase_reg >= PHASE_LAST) ? '0 : phase_reg + PHASE_W'(1);
                if (column_plus >= width_eff)
                begin
                    column_next = '0;
                    if (row_reg != COORD_ONES)
                        row_next = row_reg + COORD_W'(1);
                end
                else
                begin
                    column_next = column_reg + COORD_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_reg  <= '0;
            row_reg     <= '0;
            phase_reg   <= '0;
            min_col_reg <= COORD_ONES;
            max_col_reg <= '0;
            min_row_reg <= COORD_ONES;
            max_row_reg <= '0;
            any_reg     <= 1'b0;
        end
        else
        begin
            column_reg  <= column_next;
            row_reg     <= row_next;
            phase_reg   <= phase_next;
            min_col_reg <= min_col_next;
            max_col_reg <= max_col_next;
            min_row_reg <= min_row_next;
            max_row_reg <= max_row_next;
            any_reg     <= any_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/frame_diff_bounding_box.sv =====
`default_nettype none

// Frame difference bounding box: takes one pixel pair per clock in raster
// order, unless a result waiting on m_axis_tready stalls the input, tests
// every fourth pixel for a summed blue, green and red difference above
// diff_threshold, and on the request marked tlast returns one result with
// found in tuser and the box of changed pixels in tdata. The box registers
// are updated once per pixel; the result passes the input register, then
// the result register. Write configuration through cfg_we, cfg_index and
// cfg_data only while no frame is in flight; the block does not enforce it.
module frame_diff_bounding_box (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_we,
    input  wire logic [fdbb_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [fdbb_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    // a_blue, a_green, a_red, b_blue, b_green, b_red
    input  wire logic [47:0]                         s_axis_tdata,
    input  wire logic                                s_axis_tlast,
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    // box_left, box_top, box_right, box_bottom
    output logic [47:0]                              m_axis_tdata,
    // found
    output logic                                     m_axis_tuser
);
    import fdbb_pkg::*;

    logic [WIDTH_W-1:0]         frame_width_reg;
    logic signed [THRESH_W-1:0] threshold_reg;

    logic        in_valid_reg;
    pixel_pair_t pixel_reg;
    logic        last_reg;

    logic        out_valid_reg;
    box_t        out_box_reg;

    logic        advance;
    logic        changed;
    box_t        result;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg <= FRAME_WIDTH_RESET;
            threshold_reg   <= THRESHOLD_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_FRAME_WIDTH:    frame_width_reg <= cfg_data[WIDTH_W-1:0];
                CFG_DIFF_THRESHOLD: threshold_reg   <= $signed(cfg_data[THRESH_W-1:0]);
                default:            ;
            endcase
        end
    end

    // A pixel is processed when the result register is free or being emptied.
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tready)
            in_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            pixel_reg <= pixel_pair_t'(s_axis_tdata);
            last_reg  <= s_axis_tlast;
        end
    end

    fdbb_pixel_diff u_diff (
        .pixel     (pixel_reg),
        .threshold (threshold_reg),
        .changed   (changed)
    );

    fdbb_box_tracker u_tracker (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (advance),
        .changed     (changed),
        .last        (last_reg),
        .frame_width (frame_width_reg),
        .result      (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance && last_reg)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance && last_reg)
            out_box_reg <= result;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_box_reg.found;
    assign m_axis_tdata  = {out_box_reg.box_bottom, out_box_reg.box_right,
                            out_box_reg.box_top, out_box_reg.box_left};

endmodule

`default_nettype wire

// ===== tb/sv/bbox_checker.sv =====
module bbox_checker
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [fdbb_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [fdbb_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             pix_valid,
    input  logic                             pix_ready,
    // a_blue, a_green, a_red, b_blue, b_green, b_red
    input  logic [47:0]                      pix_data,
    input  logic                             pix_last,
    input  logic                             box_valid,
    input  logic                             box_ready,
    // box_left, box_top, box_right, box_bottom
    input  logic [47:0]                      box_data,
    // found
    input  logic                             box_found,
    output int                               mismatches,
    output int                               boxes_pending
);

    localparam int COORD_W = fdbb_pkg::COORD_W;

    logic [fdbb_pkg::WIDTH_W-1:0]         width_reg;
    logic signed [fdbb_pkg::THRESH_W-1:0] thresh_reg;

    logic [COORD_W-1:0]           col;
    logic [COORD_W-1:0]           row;
    logic [COORD_W-1:0]           min_col;
    logic [COORD_W-1:0]           max_col;
    logic [COORD_W-1:0]           min_row;
    logic [COORD_W-1:0]           max_row;
    logic [fdbb_pkg::PHASE_W-1:0] phase;
    logic                         any_hit;

    fdbb_pkg::box_t boxes_due[$];
    int             err_total = 0;

    function automatic int chan_dist(input logic [7:0] a, input logic [7:0] b);
        return (a > b) ? int'(a) - int'(b) : int'(b) - int'(a);
    endfunction

    task automatic start_frame();
        col     = '0;
        row     = '0;
        phase   = '0;
        min_col = '1;
        max_col = '0;
        min_row = '1;
        max_row = '0;
        any_hit = 1'b0;
    endtask

    // Folds a pixel into the box and advances the raster position by one pixel,
    // or queues the box and starts a new frame when the pixel closes the frame.
    task automatic fold_pixel(input fdbb_pkg::pixel_pair_t px, input logic closes);
        int             eff_w;
        int             pix_sum;
        fdbb_pkg::box_t box;
        if (width_reg == 0)
            eff_w = 1;
        else if (int'(width_reg) > fdbb_pkg::MAX_DIM)
            eff_w = fdbb_pkg::MAX_DIM;
        else
            eff_w = int'(width_reg);

        if (phase == 0)
        begin
            pix_sum = chan_dist(px.a_blue, px.b_blue) + chan_dist(px.a_green, px.b_green)
                    + chan_dist(px.a_red, px.b_red);
            if (pix_sum > int'(thresh_reg))
            begin
                if (col < min_col) min_col = col;
                if (col > max_col) max_col = col;
                if (row < min_row) min_row = row;
                if (row > max_row) max_row = row;
                any_hit = 1'b1;
            end
        end

        if (closes)
        begin
            box = '0;
            if (any_hit)
            begin
                box.found      = 1'b1;
                box.box_left   = min_col;
                box.box_top    = min_row;
                box.box_right  = max_col;
                box.box_bottom = max_row;
            end
            boxes_due.push_back(box);
            start_frame();
        end
        else
        begin
            phase = (int'(phase) + 1 >= fdbb_pkg::SAMPLE_STEP) ? '0 : phase + 1'b1;
            if (int'(col) + 1 >= eff_w)
            begin
                col = '0;
                // The row counter sticks at the largest coordinate.
                if (int'(row) + 1 < fdbb_pkg::MAX_DIM)
                    row = row + 1'b1;
            end
            else
            begin
                col = col + 1'b1;
            end
        end
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            err_total++;
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : box_watch
        fdbb_pkg::box_t want;
        if (!rst_n)
        begin
            width_reg  = fdbb_pkg::FRAME_WIDTH_RESET;
            thresh_reg = fdbb_pkg::THRESHOLD_RESET;
            start_frame();
            boxes_due.delete();
            boxes_pending <= 0;
            mismatches    <= err_total;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == fdbb_pkg::CFG_FRAME_WIDTH)
                    width_reg = cfg_data[fdbb_pkg::WIDTH_W-1:0];
                else if (cfg_index == fdbb_pkg::CFG_DIFF_THRESHOLD)
                    thresh_reg = cfg_data[fdbb_pkg::THRESH_W-1:0];
            end

            if (pix_valid && pix_ready)
                fold_pixel(fdbb_pkg::pixel_pair_t'(pix_data), pix_last);

            if (box_valid && box_ready)
            begin
                if (boxes_due.size() == 0)
                begin
                    err_total++;
                    $display("%0t: box expected none, got found=%0b data=%h",
                             $time, box_found, box_data);
                end
                else
                begin
                    want = boxes_due.pop_front();
                    check_field("found", int'(want.found), int'(box_found));
                    check_field("box_left", int'(want.box_left), int'(box_data[11:0]));
                    check_field("box_top", int'(want.box_top), int'(box_data[23:12]));
                    check_field("box_right", int'(want.box_right), int'(box_data[35:24]));
                    check_field("box_bottom", int'(want.box_bottom),
                                int'(box_data[47:36]));
                end
            end

            mismatches    <= err_total;
            boxes_pending <= boxes_due.size();
        end
    end

endmodule

// ===== tb/sv/tb.sv =====
module tb;
    import fdbb_pkg::*;

    localparam int QUIET_LIMIT = 2000;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;
    logic                   pix_valid = 1'b0;
    logic                   pix_ready;
    logic [47:0]            pix_data  = '0;
    logic                   pix_last  = 1'b0;
    logic                   box_valid;
    logic                   box_ready = 1'b0;
    logic [47:0]            box_data;
    logic                   box_found;

    int mismatches;
    int boxes_pending;
    int quiet_cycles = 0;
    int pixels_sent  = 0;
    bit idling       = 1'b1;

    frame_diff_bounding_box u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (pix_valid),
        .s_axis_tready (pix_ready),
        .s_axis_tdata  (pix_data),
        .s_axis_tlast  (pix_last),
        .m_axis_tvalid (box_valid),
        .m_axis_tready (box_ready),
        .m_axis_tdata  (box_data),
        .m_axis_tuser  (box_found)
    );

    bbox_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .pix_valid     (pix_valid),
        .pix_ready     (pix_ready),
        .pix_data      (pix_data),
        .pix_last      (pix_last),
        .box_valid     (box_valid),
        .box_ready     (box_ready),
        .box_data      (box_data),
        .box_found     (box_found),
        .mismatches    (mismatches),
        .boxes_pending (boxes_pending)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    function automatic pixel_pair_t pixel_of(input logic [7:0] ab, input logic [7:0] ag,
                                             input logic [7:0] ar, input logic [7:0] bb,
                                             input logic [7:0] bg, input logic [7:0] br);
        pixel_pair_t px;
        px.a_blue  = ab;
        px.a_green = ag;
        px.a_red   = ar;
        px.b_blue  = bb;
        px.b_green = bg;
        px.b_red   = br;
        return px;
    endfunction

    function automatic logic [7:0] jitter(input logic [7:0] v);
        int t;
        t = $urandom_range(0, 24);
        t = t + int'(v) - 12;
        if (t < 0) t = 0;
        if (t > 255) t = 255;
        return t[7:0];
    endfunction

    // Mostly small differences so that the threshold decides, now and then
    // an unrelated pair of pixels.
    function automatic pixel_pair_t rand_pixel();
        logic [63:0] raw;
        pixel_pair_t px;
        raw = {$urandom(), $urandom()};
        px  = raw[47:0];
        if ($urandom_range(0, 2) != 0)
        begin
            px.b_blue  = jitter(px.a_blue);
            px.b_green = jitter(px.a_green);
            px.b_red   = jitter(px.a_red);
        end
        return px;
    endfunction

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input int value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[CFG_DATA_W-1:0];
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic send_pixel(input pixel_pair_t px, input logic closes);
        if (idling && $urandom_range(0, 3) == 0)
        begin
            pix_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        pix_valid <= 1'b1;
        pix_data  <= px;
        pix_last  <= closes;
        @(posedge clk);
        while (!pix_ready) @(posedge clk);
        pixels_sent++;
    endtask

    task automatic send_frame(input int len);
        for (int i = 0; i < len; i++)
            send_pixel(rand_pixel(), i == len - 1);
    endtask

    // Waits until every box that the checker expects has left, then idles on
    // to make sure the block is quiet.
    task automatic settle();
        pix_valid <= 1'b0;
        do @(posedge clk); while (boxes_pending != 0);
        repeat (4) @(posedge clk);
    endtask

    initial
    begin
        int stall;
        stall = 0;
        forever
        begin
            @(posedge clk);
            if (stall == 0 && idling && $urandom_range(0, 4) == 0)
                stall = $urandom_range(1, 6);
            if (stall > 0)
            begin
                box_ready <= 1'b0;
                stall--;
            end
            else
            begin
                box_ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (cfg_we || (pix_valid && pix_ready) || (box_valid && box_ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: single-pixel frames with no change and with the
        // largest change.
        send_pixel(pixel_of(0, 0, 0, 0, 0, 0), 1'b1);
        send_pixel(pixel_of(255, 255, 255, 0, 0, 0), 1'b1);

        // Large changes off the sample points are ignored, and a sum equal
        // to the threshold does not count.
        send_pixel(pixel_of(7, 7, 7, 7, 7, 7), 1'b0);
        repeat (3) send_pixel(pixel_of(255, 255, 255, 0, 0, 0), 1'b0);
        send_pixel(pixel_of(10, 10, 10, 0, 0, 0), 1'b0);
        send_pixel(pixel_of(0, 0, 0, 255, 255, 255), 1'b1);

        // One above the threshold on the closing pixel still counts.
        repeat (4) send_pixel(pixel_of(90, 40, 200, 90, 40, 200), 1'b0);
        send_pixel(pixel_of(0, 0, 0, 11, 10, 10), 1'b1);

        settle();
        write_reg(CFG_DIFF_THRESHOLD, 765);
        send_pixel(pixel_of(255, 0, 255, 0, 255, 0), 1'b1);

        // A negative threshold marks every sampled pixel as changed.
        settle();
        write_reg(CFG_FRAME_WIDTH, 2);
        write_reg(CFG_DIFF_THRESHOLD, -1);
        repeat (5) send_pixel(pixel_of(3, 3, 3, 3, 3, 3), 1'b1 == 1'b0);
        send_pixel(pixel_of(3, 3, 3, 3, 3, 3), 1'b1);

        // One pixel per row over many rows, then a frame under an oversized
        // width setting.
        settle();
        write_reg(CFG_FRAME_WIDTH, 1);
        write_reg(CFG_DIFF_THRESHOLD, 20);
        send_frame(40);
        settle();
        write_reg(CFG_FRAME_WIDTH, 8191);
        write_reg(CFG_DIFF_THRESHOLD, 30);
        send_frame(40);

        while (pixels_sent < 500)
        begin
            settle();
            case ($urandom_range(0, 9))
                0:       write_reg(CFG_FRAME_WIDTH, 0);
                1:       write_reg(CFG_FRAME_WIDTH, 8191);
                2:       write_reg(CFG_FRAME_WIDTH, 4096);
                3:       write_reg(CFG_FRAME_WIDTH, $urandom_range(1, 4096));
                default: write_reg(CFG_FRAME_WIDTH, $urandom_range(1, 8));
            endcase
            case ($urandom_range(0, 7))
                0:       write_reg(CFG_DIFF_THRESHOLD, -1);
                1:       write_reg(CFG_DIFF_THRESHOLD, 765);
                2:       write_reg(CFG_DIFF_THRESHOLD, $urandom_range(0, 8191));
                default: write_reg(CFG_DIFF_THRESHOLD, $urandom_range(0, 60));
            endcase
            repeat (3) send_frame($urandom_range(1, 30));
            if (pixels_sent > 400)
                idling = 1'b0;
        end

        settle();
        repeat (4) @(posedge clk);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
